// File: design/vector_stroke_text_generator_assert.svh
// ----------------------------------------------------------------------------
// Vector stroke text generator - assertion macros
// Shared forms for the concurrent checks of the generator. Each check is
// clocked on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef VECTOR_STROKE_TEXT_GENERATOR_ASSERT_SVH
`define VECTOR_STROKE_TEXT_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSTG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VSTG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vstg_pkg.sv
// ----------------------------------------------------------------------------
// Vector stroke text generator - package
// Register indexes, character codes, glyph lookup and shared types.
// ----------------------------------------------------------------------------
package vstg_pkg;

  localparam int CHAR_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int GLYPH_IDX_W = 6;
  localparam int SEG_IDX_W   = 3;
  localparam int NUM_GLYPHS  = 36;
  localparam int MAX_SEGS    = 6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_MARGIN_X  = 3'd2,
    REG_MARGIN_Y  = 3'd3,
    REG_SCALE     = 3'd4,
    REG_TAB_WIDTH = 3'd5
  } reg_index_t;

  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

  // One stroke: a nibble per grid digit, x0 y0 x1 y1 from the top down.
  typedef logic [15:0] seg_word_t;

  // Cursor moves requested of the cursor unit.
  typedef struct packed {
    logic advance;
    logic tab;
    logic line;
  } move_t;

  typedef struct packed {
    logic                   hit;
    logic [GLYPH_IDX_W-1:0] idx;
  } glyph_sel_t;

  function automatic glyph_sel_t glyph_lookup(input logic [CHAR_W-1:0] code);
    glyph_sel_t sel;
    sel.hit = 1'b1;
    sel.idx = '0;
    if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
      sel.idx = GLYPH_IDX_W'(code - CHAR_UPPER_A);
    end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      sel.idx = GLYPH_IDX_W'(code - CHAR_LOWER_A);
    end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
      sel.idx = GLYPH_IDX_W'(code - CHAR_ZERO) + GLYPH_IDX_W'(26);
    end else begin
      sel.hit = 1'b0;
    end
    return sel;
  endfunction

endpackage

// File: design/vstg_ifs.sv
// ----------------------------------------------------------------------------
// Vector stroke text generator - channel interfaces
// Character input, segment output and register write channels.
// ----------------------------------------------------------------------------
interface vstg_char_if;
  logic                         valid;
  logic                         ready;
  logic [vstg_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface vstg_seg_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] seg_x0;
  logic [COORD_BITS-1:0] seg_y0;
  logic [COORD_BITS-1:0] seg_x1;
  logic [COORD_BITS-1:0] seg_y1;
  logic                  last_segment;

  modport source (output valid, output seg_x0, output seg_y0, output seg_x1,
                  output seg_y1, output last_segment, input ready);
  modport sink   (input valid, input seg_x0, input seg_y0, input seg_x1,
                  input seg_y1, input last_segment, output ready);
endinterface

interface vstg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vstg_pkg::CFG_INDEX_W-1:0] index;
  logic [vstg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/vstg_font_rom.sv
// ----------------------------------------------------------------------------
// Vector stroke text generator - font memory
// Stroke font with a registered read port: one stroke of one glyph a cycle,
// together with a flag for the glyph's final stroke.
// ----------------------------------------------------------------------------
module vstg_font_rom (
  input  logic                                clk,
  input  logic [vstg_pkg::GLYPH_IDX_W-1:0]    glyph,
  input  logic [vstg_pkg::SEG_IDX_W-1:0]      seg_idx,
  output vstg_pkg::seg_word_t                 word,
  output logic                                last
);

  typedef logic [0:vstg_pkg::MAX_SEGS-1][15:0] font_row_t;

  function automatic font_row_t font_row(input logic [vstg_pkg::GLYPH_IDX_W-1:0] g);
    font_row_t row;
    case (g)
      6'd0:  row = {16'h0002, 16'h2022, 16'h0020, 16'h0121, 16'h0, 16'h0};
      6'd1:  row = {16'h0002, 16'h2122, 16'h0020, 16'h0121, 16'h0222, 16'h1120};
      6'd2:  row = {16'h0002, 16'h0020, 16'h0222, 16'h0, 16'h0, 16'h0};
      6'd3:  row = {16'h0002, 16'h2021, 16'h0020, 16'h0212, 16'h1221, 16'h0};
      6'd4:  row = {16'h0002, 16'h0020, 16'h0111, 16'h0222, 16'h0, 16'h0};
      6'd5:  row = {16'h0002, 16'h0020, 16'h0111, 16'h0, 16'h0, 16'h0};
      6'd6:  row = {16'h0002, 16'h2122, 16'h0020, 16'h1121, 16'h0222, 16'h0};
      6'd7:  row = {16'h0002, 16'h2022, 16'h0121, 16'h0, 16'h0, 16'h0};
      6'd8:  row = {16'h1012, 16'h0020, 16'h0222, 16'h0, 16'h0, 16'h0};
      6'd9:  row = {16'h0102, 16'h2022, 16'h0222, 16'h0, 16'h0, 16'h0};
      6'd10: row = {16'h0002, 16'h0120, 16'h0122, 16'h0, 16'h0, 16'h0};
      6'd11: row = {16'h0002, 16'h0222, 16'h0, 16'h0, 16'h0, 16'h0};
      6'd12: row = {16'h0002, 16'h2022, 16'h0012, 16'h1220, 16'h0, 16'h0};
      6'd13: row = {16'h0002, 16'h2022, 16'h0022, 16'h0, 16'h0, 16'h0};
      6'd14: row = {16'h0002, 16'h2022, 16'h0020, 16'h0222, 16'h0, 16'h0};
      6'd15: row = {16'h0002, 16'h2021, 16'h0020, 16'h0121, 16'h0, 16'h0};
      6'd16: row = {16'h0002, 16'h2021, 16'h0020, 16'h0212, 16'h1122, 16'h1221};
      6'd17: row = {16'h0002, 16'h2021, 16'h0020, 16'h0121, 16'h1122, 16'h0};
      6'd18: row = {16'h0001, 16'h2122, 16'h0020, 16'h0121, 16'h0222, 16'h0};
      6'd19: row = {16'h1012, 16'h0020, 16'h0, 16'h0, 16'h0, 16'h0};
      6'd20: row = {16'h0002, 16'h2022, 16'h0222, 16'h0, 16'h0, 16'h0};
      6'd21: row = {16'h0012, 16'h1220, 16'h0, 16'h0, 16'h0, 16'h0};
      6'd22: row = {16'h0002, 16'h2022, 16'h0211, 16'h1122, 16'h0, 16'h0};
      6'd23: row = {16'h0022, 16'h0220, 16'h0, 16'h0, 16'h0, 16'h0};
      6'd24: row = {16'h1112, 16'h0011, 16'h1120, 16'h0, 16'h0, 16'h0};
      6'd25: row = {16'h0020, 16'h0121, 16'h0222, 16'h0220, 16'h0, 16'h0};
      6'd26: row = {16'h0002, 16'h2022, 16'h0020, 16'h0222, 16'h0220, 16'h0};
      6'd27: row = {16'h1012, 16'h0222, 16'h0110, 16'h0, 16'h0, 16'h0};
      6'd28: row = {16'h0102, 16'h2021, 16'h0020, 16'h0121, 16'h0222, 16'h0};
      6'd29: row = {16'h2122, 16'h0020, 16'h1121, 16'h0222, 16'h1120, 16'h0};
      6'd30: row = {16'h1012, 16'h0121, 16'h0110, 16'h0, 16'h0, 16'h0};
      6'd31: row = {16'h0001, 16'h0020, 16'h0121, 16'h0212, 16'h1221, 16'h0};
      6'd32: row = {16'h0002, 16'h2122, 16'h0020, 16'h0121, 16'h0222, 16'h0};
      6'd33: row = {16'h0020, 16'h1220, 16'h0, 16'h0, 16'h0, 16'h0};
      6'd34: row = {16'h0002, 16'h2022, 16'h0020, 16'h0121, 16'h0222, 16'h0};
      6'd35: row = {16'h0001, 16'h2022, 16'h0020, 16'h0121, 16'h0, 16'h0};
      default: row = '0;
    endcase
    return row;
  endfunction

  function automatic logic [vstg_pkg::SEG_IDX_W-1:0] font_count(
    input logic [vstg_pkg::GLYPH_IDX_W-1:0] g
  );
    logic [vstg_pkg::SEG_IDX_W-1:0] n;
    case (g)
      6'd1, 6'd16: n = 3'd6;
      6'd3, 6'd6, 6'd17, 6'd18, 6'd26, 6'd28, 6'd29, 6'd31, 6'd32, 6'd34: n = 3'd5;
      6'd0, 6'd4, 6'd12, 6'd14, 6'd15, 6'd22, 6'd25, 6'd35: n = 3'd4;
      6'd11, 6'd19, 6'd21, 6'd23, 6'd33: n = 3'd2;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

  font_row_t                      row;
  logic [vstg_pkg::SEG_IDX_W-1:0] count;

  always_comb begin
    row   = font_row(glyph);
    count = font_count(glyph);
  end

  always_ff @(posedge clk) begin
    if (seg_idx < vstg_pkg::SEG_IDX_W'(vstg_pkg::MAX_SEGS)) begin
      word <= row[seg_idx];
    end else begin
      word <= '0;
    end
    last <= (seg_idx == count - 3'd1);
  end

endmodule

// File: design/vstg_cursor.sv
// ----------------------------------------------------------------------------
// Vector stroke text generator - cursor and register unit
// Holds the configuration registers and the cursor, keeps the cell, tab and
// line steps in registers, and applies saturating cursor moves.
// ----------------------------------------------------------------------------
module vstg_cursor #(
  parameter int GLYPH_WIDTH  = 3,
  parameter int GLYPH_HEIGHT = 3,
  parameter int COORD_BITS   = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  vstg_cfg_if.sink              cfg,
  input  vstg_pkg::move_t       move,
  output logic [COORD_BITS-1:0] cursor_x,
  output logic [COORD_BITS-1:0] cursor_y,
  output logic [4:0]            scale
);

  localparam int ADV_MAX  = GLYPH_WIDTH * 31 + 126;
  localparam int ADV_W    = $clog2(ADV_MAX + 1);
  localparam int TAB_W    = $clog2(ADV_MAX * 31 + 1);
  localparam int LINE_W   = $clog2(GLYPH_HEIGHT * 31 + 127);
  localparam int STEP_W   = (TAB_W > LINE_W) ? TAB_W : LINE_W;
  localparam int SUM_W    = ((COORD_BITS > STEP_W) ? COORD_BITS : STEP_W) + 1;
  localparam int CLAMP_W  = (COORD_BITS > vstg_pkg::CFG_DATA_W) ?
                            COORD_BITS : vstg_pkg::CFG_DATA_W;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [6:0]            margin_x;
  logic [6:0]            margin_y;
  logic [4:0]            tab_width;
  logic [ADV_W-1:0]      adv_cell;
  logic [ADV_W-1:0]      adv_cell_next;
  logic [TAB_W-1:0]      adv_tab;
  logic [TAB_W-1:0]      adv_tab_next;
  logic [LINE_W-1:0]     adv_line;
  logic [LINE_W-1:0]     adv_line_next;
  logic [6:0]            mx_less;
  logic [6:0]            my_less;
  logic [CLAMP_W-1:0]    wr_wide;
  logic [COORD_BITS-1:0] wr_coord;
  logic                  wr_en;

  function automatic logic [COORD_BITS-1:0] sat_add(
    input logic [COORD_BITS-1:0] a,
    input logic [STEP_W-1:0]     b
  );
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(COORD_MAX)) ? COORD_BITS'(COORD_MAX) : s[COORD_BITS-1:0];
  endfunction

  assign cfg.ready = 1'b1;

  always_comb begin
    wr_en    = cfg.valid && cfg.ready;
    wr_wide  = CLAMP_W'(cfg.data);
    wr_coord = (wr_wide > CLAMP_W'(COORD_MAX)) ? COORD_BITS'(COORD_MAX)
                                               : wr_wide[COORD_BITS-1:0];
    // A margin of zero contributes nothing rather than wrapping.
    mx_less  = (margin_x == 7'd0) ? 7'd0 : margin_x - 7'd1;
    my_less  = (margin_y == 7'd0) ? 7'd0 : margin_y - 7'd1;
    adv_cell_next = ADV_W'(GLYPH_WIDTH) * ADV_W'(scale) + ADV_W'(mx_less);
    adv_line_next = LINE_W'(GLYPH_HEIGHT) * LINE_W'(scale) + LINE_W'(my_less);
    adv_tab_next  = TAB_W'(adv_cell) * TAB_W'(tab_width);
  end

  // Steps are registered; the tab step uses the registered cell step.
  always_ff @(posedge clk) begin
    if (rst) begin
      adv_cell <= ADV_W'(GLYPH_WIDTH);
      adv_line <= LINE_W'(GLYPH_HEIGHT);
      adv_tab  <= TAB_W'(GLYPH_WIDTH);
    end else begin
      adv_cell <= adv_cell_next;
      adv_line <= adv_line_next;
      adv_tab  <= adv_tab_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      margin_x  <= 7'd1;
      margin_y  <= 7'd1;
      scale     <= 5'd1;
      tab_width <= 5'd1;
      cursor_x  <= '0;
      cursor_y  <= '0;
    end else begin
      if (move.advance) begin
        cursor_x <= sat_add(cursor_x, STEP_W'(adv_cell));
      end
      if (move.tab) begin
        cursor_x <= sat_add(cursor_x, STEP_W'(adv_tab));
      end
      if (move.line) begin
        cursor_x <= start_x;
        cursor_y <= sat_add(cursor_y, STEP_W'(adv_line));
      end
      if (wr_en) begin
        case (cfg.index)
          vstg_pkg::REG_START_X: begin
            start_x  <= wr_coord;
            cursor_x <= wr_coord;
          end
          vstg_pkg::REG_START_Y: begin
            start_y  <= wr_coord;
            cursor_y <= wr_coord;
          end
          vstg_pkg::REG_MARGIN_X:  margin_x  <= cfg.data[6:0];
          vstg_pkg::REG_MARGIN_Y:  margin_y  <= cfg.data[6:0];
          vstg_pkg::REG_SCALE:     scale     <= cfg.data[4:0];
          vstg_pkg::REG_TAB_WIDTH: tab_width <= cfg.data[4:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: design/vstg_seg_unit.sv
// ----------------------------------------------------------------------------
// Vector stroke text generator - segment output stage
// Scales the grid digits of one stroke, adds the cursor with saturation and
// holds the finished word in the output register until it is taken.
// ----------------------------------------------------------------------------
module vstg_seg_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  vstg_pkg::seg_word_t   word,
  input  logic                  last,
  input  logic [COORD_BITS-1:0] cursor_x,
  input  logic [COORD_BITS-1:0] cursor_y,
  input  logic [4:0]            scale,
  output logic                  free,
  vstg_seg_if.source            segs
);

  function automatic logic [COORD_BITS-1:0] place(
    input logic [COORD_BITS-1:0] base,
    input logic [1:0]            digit,
    input logic [4:0]            mult
  );
    logic [6:0]            offset;
    logic [COORD_BITS:0]   s;
    offset = 7'({5'd0, digit} * {2'd0, mult});
    s      = {1'b0, base} + (COORD_BITS + 1)'(offset);
    return s[COORD_BITS] ? '1 : s[COORD_BITS-1:0];
  endfunction

  logic out_valid;

  assign free       = !out_valid || segs.ready;
  assign segs.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (segs.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      segs.seg_x0       <= place(cursor_x, word[13:12], scale);
      segs.seg_y0       <= place(cursor_y, word[9:8], scale);
      segs.seg_x1       <= place(cursor_x, word[5:4], scale);
      segs.seg_y1       <= place(cursor_y, word[1:0], scale);
      segs.last_segment <= last;
    end
  end

endmodule

// File: design/vector_stroke_text_generator.sv
// ----------------------------------------------------------------------------
// Vector stroke text generator: a glyph of 2 to 6 strokes is loaded into the output register
// stroke by stroke in S_EMIT, paced by the font memory read port at one stroke a cycle while
// it is free; space, tab, newline pass S_PREP and S_MOVE; characters are taken in S_IDLE only.
// Synchronous reset: cursor and start at 0, margins, scale and tab width at 1; no clearing pass.
// ----------------------------------------------------------------------------
`include "vector_stroke_text_generator_assert.svh"

module vector_stroke_text_generator #(
  parameter int GLYPH_WIDTH  = 3,
  parameter int GLYPH_HEIGHT = 3,
  parameter int COORD_BITS   = 12
) (
  input  logic        clk,
  input  logic        rst,
  vstg_char_if.sink   chars,
  vstg_seg_if.source  segs,
  vstg_cfg_if.sink    cfg
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EMIT = 4'b0010,
    S_PREP = 4'b0100,
    S_MOVE = 4'b1000
  } state_t;

  state_t                              state;
  state_t                              state_next;
  logic [vstg_pkg::GLYPH_IDX_W-1:0]    glyph;
  logic [vstg_pkg::SEG_IDX_W-1:0]      seg_idx;
  vstg_pkg::move_t                     pending;
  vstg_pkg::move_t                     cmd;
  vstg_pkg::glyph_sel_t                lookup;
  logic                                in_take;
  logic                                free;
  logic                                load;
  logic [vstg_pkg::GLYPH_IDX_W-1:0]    rom_glyph;
  logic [vstg_pkg::SEG_IDX_W-1:0]      rom_seg;
  vstg_pkg::seg_word_t                 rom_word;
  logic                                rom_last;
  logic [COORD_BITS-1:0]               cursor_x;
  logic [COORD_BITS-1:0]               cursor_y;
  logic [4:0]                          scale;

  always_comb begin
    lookup      = vstg_pkg::glyph_lookup(chars.char_code);
    chars.ready = (state == S_IDLE);
    in_take     = chars.valid && chars.ready;
    load        = (state == S_EMIT) && free;
    // The read for the next stroke is issued as the current one is loaded.
    rom_glyph   = (state == S_IDLE) ? lookup.idx : glyph;
    if (state == S_IDLE) begin
      rom_seg = '0;
    end else if (load) begin
      rom_seg = seg_idx + 3'd1;
    end else begin
      rom_seg = seg_idx;
    end
    cmd.advance = (load && rom_last) || ((state == S_MOVE) && pending.advance);
    cmd.tab     = (state == S_MOVE) && pending.tab;
    cmd.line    = (state == S_MOVE) && pending.line;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take && lookup.hit) begin
          state_next = S_EMIT;
        end else if (in_take && (chars.char_code == vstg_pkg::CHAR_SPACE ||
                                 chars.char_code == vstg_pkg::CHAR_TAB ||
                                 chars.char_code == vstg_pkg::CHAR_NEWLINE)) begin
          state_next = S_PREP;
        end
      end
      S_EMIT: begin
        if (load && rom_last) begin
          state_next = S_IDLE;
        end
      end
      // S_PREP is slack so that the tab step reflects the latest registers.
      S_PREP:  state_next = S_MOVE;
      S_MOVE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      seg_idx <= '0;
      pending <= '0;
    end else begin
      state <= state_next;
      if (in_take) begin
        seg_idx         <= '0;
        pending.advance <= (chars.char_code == vstg_pkg::CHAR_SPACE);
        pending.tab     <= (chars.char_code == vstg_pkg::CHAR_TAB);
        pending.line    <= (chars.char_code == vstg_pkg::CHAR_NEWLINE);
      end else if (load) begin
        seg_idx <= seg_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      glyph <= lookup.idx;
    end
  end

  vstg_font_rom u_font (
    .clk     (clk),
    .glyph   (rom_glyph),
    .seg_idx (rom_seg),
    .word    (rom_word),
    .last    (rom_last)
  );

  vstg_cursor #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .COORD_BITS   (COORD_BITS)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .move     (cmd),
    .cursor_x (cursor_x),
    .cursor_y (cursor_y),
    .scale    (scale)
  );

  vstg_seg_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_seg (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .word     (rom_word),
    .last     (rom_last),
    .cursor_x (cursor_x),
    .cursor_y (cursor_y),
    .scale    (scale),
    .free     (free),
    .segs     (segs)
  );

  `VSTG_ASSERT_IMP(a_seg_in_range, state == S_EMIT, seg_idx < 3'd6, "stroke index ran past the glyph")
  `VSTG_ASSERT_NXT(a_glyph_starts, in_take && lookup.hit, state == S_EMIT, "glyph did not start emitting")
  `VSTG_ASSERT_NXT(a_last_ends, load && rom_last, state == S_IDLE, "final stroke did not end the glyph")
  `VSTG_ASSERT_IMP(a_single_move, 1'b1, $onehot0(cmd), "more than one cursor move at once")

endmodule

// File: tb/vector_stroke_text_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector stroke text generator - self-checking testbench
// Characters are fed through a queue-driven driver while a monitor compares
// every stroke word against a local model of the font and the text cursor.
// Register settings change between phases. The idle ratios on both sides
// shift between groups of phases, and one phase holds the output off for a
// long stretch.
// ----------------------------------------------------------------------------
module vector_stroke_text_generator_tb;

  localparam int GLYPH_W      = 3;
  localparam int GLYPH_H      = 3;
  localparam int COORD_MAX    = 4095;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [vstg_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [vstg_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [11:0] x0;
    logic [11:0] y0;
    logic [11:0] x1;
    logic [11:0] y1;
    logic        last;
  } stroke_t;

  logic clk;
  logic rst;

  vstg_char_if                   char_ch ();
  vstg_seg_if #(.COORD_BITS(12)) seg_ch ();
  vstg_cfg_if                    cfg_ch ();

  vector_stroke_text_generator #(
    .GLYPH_WIDTH  (GLYPH_W),
    .GLYPH_HEIGHT (GLYPH_H),
    .COORD_BITS   (12)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .chars (char_ch),
    .segs  (seg_ch),
    .cfg   (cfg_ch)
  );

  // Text model: cursor, start point and spacing settings.
  int pen_x, pen_y, origin_x, origin_y, gap_x, gap_y, zoom, tab_cells;

  logic [7:0] char_backlog[$];
  stroke_t    pending_strokes[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int mismatches;
  int chars_accepted;
  int strokes_seen;
  int settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Each glyph is a list of strokes, one x0 y0 x1 y1 digit group per stroke.
  function automatic string stroke_list(input int slot);
    case (slot)
      0:  return "0002 2022 0020 0121";
      1:  return "0002 2122 0020 0121 0222 1120";
      2:  return "0002 0020 0222";
      3:  return "0002 2021 0020 0212 1221";
      4:  return "0002 0020 0111 0222";
      5:  return "0002 0020 0111";
      6:  return "0002 2122 0020 1121 0222";
      7:  return "0002 2022 0121";
      8:  return "1012 0020 0222";
      9:  return "0102 2022 0222";
      10: return "0002 0120 0122";
      11: return "0002 0222";
      12: return "0002 2022 0012 1220";
      13: return "0002 2022 0022";
      14: return "0002 2022 0020 0222";
      15: return "0002 2021 0020 0121";
      16: return "0002 2021 0020 0212 1122 1221";
      17: return "0002 2021 0020 0121 1122";
      18: return "0001 2122 0020 0121 0222";
      19: return "1012 0020";
      20: return "0002 2022 0222";
      21: return "0012 1220";
      22: return "0002 2022 0211 1122";
      23: return "0022 0220";
      24: return "1112 0011 1120";
      25: return "0020 0121 0222 0220";
      26: return "0002 2022 0020 0222 0220";
      27: return "1012 0222 0110";
      28: return "0102 2021 0020 0121 0222";
      29: return "2122 0020 1121 0222 1120";
      30: return "1012 0121 0110";
      31: return "0001 0020 0121 0212 1221";
      32: return "0002 2122 0020 0121 0222";
      33: return "0020 1220";
      34: return "0002 2022 0020 0121 0222";
      default: return "0001 2022 0020 0121";
    endcase
  endfunction

  function automatic int font_slot(input logic [7:0] code);
    if (code >= vstg_pkg::CHAR_UPPER_A && code <= vstg_pkg::CHAR_UPPER_Z)
      return int'(code - vstg_pkg::CHAR_UPPER_A);
    if (code >= vstg_pkg::CHAR_LOWER_A && code <= vstg_pkg::CHAR_LOWER_Z)
      return int'(code - vstg_pkg::CHAR_LOWER_A);
    if (code >= vstg_pkg::CHAR_ZERO && code <= vstg_pkg::CHAR_NINE)
      return int'(code - vstg_pkg::CHAR_ZERO) + 26;
    return -1;
  endfunction

  function automatic logic [11:0] clip(input int v);
    return (v > COORD_MAX) ? 12'(COORD_MAX) : 12'(v);
  endfunction

  function automatic int grid(input string s, input int pos);
    return int'(s[pos]) - int'(vstg_pkg::CHAR_ZERO);
  endfunction

  // Works out the strokes of one character and moves the cursor on.
  task automatic plot_char(input logic [7:0] code);
    int      slot;
    int      count;
    int      step;
    string   s;
    stroke_t st;
    slot = font_slot(code);
    step = GLYPH_W * zoom + ((gap_x != 0) ? gap_x - 1 : 0);
    if (slot >= 0) begin
      s = stroke_list(slot);
      count = (s.len() + 1) / 5;
      for (int k = 0; k < count; k++) begin
        st.x0   = clip(pen_x + grid(s, 5 * k) * zoom);
        st.y0   = clip(pen_y + grid(s, 5 * k + 1) * zoom);
        st.x1   = clip(pen_x + grid(s, 5 * k + 2) * zoom);
        st.y1   = clip(pen_y + grid(s, 5 * k + 3) * zoom);
        st.last = (k == count - 1);
        pending_strokes.push_back(st);
      end
      pen_x = clip(pen_x + step);
    end else if (code == vstg_pkg::CHAR_SPACE) begin
      pen_x = clip(pen_x + step);
    end else if (code == vstg_pkg::CHAR_TAB) begin
      pen_x = clip(pen_x + step * tab_cells);
    end else if (code == vstg_pkg::CHAR_NEWLINE) begin
      pen_x = origin_x;
      pen_y = clip(pen_y + GLYPH_H * zoom + ((gap_y != 0) ? gap_y - 1 : 0));
    end
  endtask

  task automatic apply_reg(input logic [vstg_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [11:0] value);
    case (idx)
      vstg_pkg::REG_START_X: begin
        origin_x = int'(value);
        pen_x    = origin_x;
      end
      vstg_pkg::REG_START_Y: begin
        origin_y = int'(value);
        pen_y    = origin_y;
      end
      vstg_pkg::REG_MARGIN_X:  gap_x     = int'(value[6:0]);
      vstg_pkg::REG_MARGIN_Y:  gap_y     = int'(value[6:0]);
      vstg_pkg::REG_SCALE:     zoom      = int'(value[4:0]);
      vstg_pkg::REG_TAB_WIDTH: tab_cells = int'(value[4:0]);
      default: ;
    endcase
  endtask

  task automatic flag(input string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Sender side: accepted characters go to the model, then the next one is offered.
  always @(posedge clk) begin
    if (rst) begin
      char_ch.valid <= 1'b0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        plot_char(char_ch.char_code);
        chars_accepted++;
      end
      if (!char_ch.valid || char_ch.ready) begin
        if (char_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          char_ch.char_code <= char_backlog.pop_front();
          char_ch.valid     <= 1'b1;
        end else begin
          char_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted here and requested by the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end
  end

  // Receiver side: every stroke word is checked against the oldest expectation.
  always @(posedge clk) begin : stroke_monitor
    stroke_t want;
    if (rst) begin
      seg_ch.ready <= 1'b0;
    end else begin
      if (seg_ch.valid && seg_ch.ready) begin
        strokes_seen++;
        if (pending_strokes.size() == 0) begin
          flag($sformatf("unexpected stroke (%0d,%0d)-(%0d,%0d)", seg_ch.seg_x0,
                         seg_ch.seg_y0, seg_ch.seg_x1, seg_ch.seg_y1));
        end else begin
          want = pending_strokes.pop_front();
          check_field("seg_x0", int'(seg_ch.seg_x0), int'(want.x0));
          check_field("seg_y0", int'(seg_ch.seg_y0), int'(want.y0));
          check_field("seg_x1", int'(seg_ch.seg_x1), int'(want.x1));
          check_field("seg_y1", int'(seg_ch.seg_y1), int'(want.y1));
          check_field("last_segment", int'(seg_ch.last_segment), int'(want.last));
        end
      end
      seg_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [vstg_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [11:0] value);
    @(posedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, value);
  endtask

  // Waits until every character is taken and every stroke has come out.
  task automatic settle();
    while (char_backlog.size() != 0 || char_ch.valid || pending_strokes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 22) return vstg_pkg::CHAR_UPPER_A + 8'($urandom_range(25));
    if (r < 44) return vstg_pkg::CHAR_LOWER_A + 8'($urandom_range(25));
    if (r < 56) return vstg_pkg::CHAR_ZERO + 8'($urandom_range(9));
    if (r < 68) return vstg_pkg::CHAR_SPACE;
    if (r < 76) return vstg_pkg::CHAR_TAB;
    if (r < 84) return vstg_pkg::CHAR_NEWLINE;
    return 8'($urandom_range(255));
  endfunction

  task automatic program_random_setting();
    write_reg(vstg_pkg::REG_START_X, ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                                               : 12'($urandom_range(1500)));
    write_reg(vstg_pkg::REG_START_Y, ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                                               : 12'($urandom_range(1500)));
    write_reg(vstg_pkg::REG_MARGIN_X, ($urandom_range(4) == 0) ? 12'($urandom)
                                                                : 12'($urandom_range(64, 1)));
    write_reg(vstg_pkg::REG_MARGIN_Y, ($urandom_range(4) == 0) ? 12'($urandom)
                                                                : 12'($urandom_range(64, 1)));
    write_reg(vstg_pkg::REG_SCALE, ($urandom_range(4) == 0) ? 12'($urandom)
                                                             : 12'($urandom_range(16, 1)));
    write_reg(vstg_pkg::REG_TAB_WIDTH, ($urandom_range(4) == 0) ? 12'($urandom)
                                                                 : 12'($urandom_range(16)));
    write_reg(($urandom_range(1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, 12'($urandom));
    settings_used++;
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run timed out after %0d cycles with %0d strokes outstanding.", cycles,
             pending_strokes.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    seg_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    send_idle_pct     = 35;
    recv_idle_pct     = 68;
    hold_requests     = 0;
    mismatches        = 0;
    chars_accepted    = 0;
    strokes_seen      = 0;
    settings_used     = 1;
    origin_x  = 0;
    origin_y  = 0;
    pen_x     = 0;
    pen_y     = 0;
    gap_x     = 1;
    gap_y     = 1;
    zoom      = 1;
    tab_cells = 1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: glyphs of every kind, whitespace, and codes that do nothing.
    char_backlog.push_back("A");
    char_backlog.push_back("z");
    char_backlog.push_back("0");
    char_backlog.push_back("9");
    char_backlog.push_back("B");
    char_backlog.push_back("Q");
    char_backlog.push_back(vstg_pkg::CHAR_SPACE);
    char_backlog.push_back(vstg_pkg::CHAR_TAB);
    char_backlog.push_back(vstg_pkg::CHAR_NEWLINE);
    char_backlog.push_back(8'h00);
    char_backlog.push_back(8'hFF);
    char_backlog.push_back(8'h7F);
    char_backlog.push_back(8'h80);
    char_backlog.push_back(8'h08);
    char_backlog.push_back("@");
    char_backlog.push_back("[");
    char_backlog.push_back("{");
    char_backlog.push_back(":");
    settle();

    // Zero margins, zero scale and zero tab width.
    write_reg(vstg_pkg::REG_START_X, 12'd5);
    write_reg(vstg_pkg::REG_START_Y, 12'd7);
    write_reg(vstg_pkg::REG_MARGIN_X, 12'd0);
    write_reg(vstg_pkg::REG_MARGIN_Y, 12'd0);
    write_reg(vstg_pkg::REG_SCALE, 12'd0);
    write_reg(vstg_pkg::REG_TAB_WIDTH, 12'd0);
    settings_used++;
    char_backlog.push_back("K");
    char_backlog.push_back(vstg_pkg::CHAR_TAB);
    char_backlog.push_back(vstg_pkg::CHAR_SPACE);
    char_backlog.push_back(vstg_pkg::CHAR_NEWLINE);
    char_backlog.push_back("e");
    settle();

    // Largest values near the far corner, so that the cursor steps saturate.
    write_reg(vstg_pkg::REG_START_X, 12'd4000);
    write_reg(vstg_pkg::REG_START_Y, 12'd4080);
    write_reg(vstg_pkg::REG_MARGIN_X, 12'hFFF);
    write_reg(vstg_pkg::REG_MARGIN_Y, 12'h07F);
    write_reg(vstg_pkg::REG_SCALE, 12'hFFF);
    write_reg(vstg_pkg::REG_TAB_WIDTH, 12'h01F);
    write_reg(REG_SPARE_HI, 12'hFFF);
    settings_used++;
    char_backlog.push_back("Q");
    char_backlog.push_back("8");
    char_backlog.push_back(vstg_pkg::CHAR_TAB);
    char_backlog.push_back(vstg_pkg::CHAR_NEWLINE);
    char_backlog.push_back("B");
    settle();

    // Random text under random settings, drained halfway through each phase.
    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 35 : (ph < 6) ? 68 : 0;
      recv_idle_pct = (ph < 3) ? 68 : (ph < 6) ? 35 : 0;
      program_random_setting();
      repeat (13) char_backlog.push_back(rand_char());
      if (ph == 6) hold_requests++;
      settle();
      repeat (13) char_backlog.push_back(rand_char());
      settle();
    end

    $display("Checked %0d strokes from %0d characters under %0d register settings,",
             strokes_seen, chars_accepted, settings_used);
    $display("with shifting idle ratios on both sides and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
